[hdl/rtcm3_frame_checker_macros.svh]
// ----------------------------------------------------------------------------
// RTCM3 frame checker assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RTCM3_FRAME_CHECKER_MACROS_SVH
`define RTCM3_FRAME_CHECKER_MACROS_SVH

// Same-cycle implication.
`define RFC_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RFC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/rfc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTCM3 frame checker package
// Result item type, protocol constants, register map and CRC-24Q update.
// ----------------------------------------------------------------------------
package rfc_pkg;

    localparam logic [7:0]  PREAMBLE   = 8'hD3;
    localparam logic [24:0] CRC_POLY   = 25'h1864CFB;

    localparam logic [1:0] VERDICT_GOOD     = 2'd0;
    localparam logic [1:0] VERDICT_CRC_ERR  = 2'd1;
    localparam logic [1:0] VERDICT_FILTERED = 2'd2;

    // Register word indexes (byte address divided by four).
    localparam logic [1:0] REG_FILTER_ENABLE = 2'd0;
    localparam logic [1:0] REG_FILTER_TYPE   = 2'd1;
    localparam logic [1:0] REG_FILTER_LIMIT  = 2'd2;

    localparam logic        FILTER_ENABLE_RST = 1'b1;
    localparam logic [11:0] FILTER_TYPE_RST   = 12'd1230;
    localparam logic [10:0] FILTER_LIMIT_RST  = 11'd10;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        frame_start;
        logic        frame_last;
        logic [1:0]  verdict;
        logic [11:0] message_type;
        logic [10:0] frame_length;
    } result_t;

    // One byte of CRC-24Q, MSB first, no reflection.
    function automatic logic [23:0] crc24q_byte(logic [23:0] crc, logic [7:0] data);
        logic [24:0] c;
        c = {1'b0, crc ^ {data, 16'h0000}};
        for (int k = 0; k < 8; k++)
        begin
            c = {c[23:0], 1'b0};
            if (c[24])
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c[23:0];
    endfunction

endpackage

[hdl/rtcm3_frame_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RTCM3 frame checker
// Finds RTCM3 frames in a byte stream, checks CRC-24Q and tags every frame
// byte with start, last and a verdict for a cut-through consumer.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while byte_stall is low; the CRC-24Q byte
// update is the longest path; result items are registered in the output stage.
// A two-entry output stage (result register plus skid register) keeps the input
// open while one result waits; byte_stall is driven only from the skid register.
// Reset (rst_n low, asynchronous) empties the output stage, returns the framer
// to the hunt for a preamble and loads the filter registers with their defaults.
`include "rtcm3_frame_checker_macros.svh"

module rtcm3_frame_checker
(
    input  logic                clk,
    input  logic                rst_n,

    // Configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,

    // Received byte stream
    input  logic                byte_valid,
    output logic                byte_stall,
    input  logic [7:0]          data_byte,

    // Tagged frame bytes
    output logic                result_valid,
    input  logic                result_stall,
    output logic [7:0]          out_byte,
    output logic                frame_start,
    output logic                frame_last,
    output logic [1:0]          verdict,
    output logic [11:0]         message_type,
    output logic [10:0]         frame_length
);
    import rfc_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic        filter_enable_reg;
    logic [11:0] filter_type_reg;
    logic [10:0] filter_limit_reg;
    logic        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_enable_reg <= FILTER_ENABLE_RST;
            filter_type_reg   <= FILTER_TYPE_RST;
            filter_limit_reg  <= FILTER_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_FILTER_ENABLE: filter_enable_reg <= pwdata[0];
                REG_FILTER_TYPE:   filter_type_reg   <= pwdata[11:0];
                REG_FILTER_LIMIT:  filter_limit_reg  <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_FILTER_ENABLE: prdata = {31'd0, filter_enable_reg};
            REG_FILTER_TYPE:   prdata = {20'd0, filter_type_reg};
            REG_FILTER_LIMIT:  prdata = {21'd0, filter_limit_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Framer state. pos_reg is the index of the next byte inside
    // the frame; the preamble is byte 0 and the header ends at byte 2.
    // ------------------------------------------------------------------
    logic        in_frame_reg,  in_frame_next;
    logic [10:0] pos_reg,       pos_next;
    logic [9:0]  plen_reg,      plen_next;
    logic [23:0] crc_reg,       crc_next;
    logic [7:0]  hdr1_reg,      hdr1_next;
    logic [7:0]  first_pl_reg,  first_pl_next;
    logic [11:0] type_reg,      type_next;
    logic [15:0] trail_reg,     trail_next;

    logic        byte_take;
    logic        res_valid;
    result_t     res;
    logic [10:0] crc_end_pos;
    logic [10:0] last_pos;
    logic [10:0] total_len;
    logic [23:0] crc_rx;
    logic [23:0] crc_upd;
    logic        at_last;

    assign byte_take   = byte_valid && !byte_stall;
    assign crc_end_pos = {1'b0, plen_reg} + 11'd3;
    assign last_pos    = {1'b0, plen_reg} + 11'd5;
    assign total_len   = {1'b0, plen_reg} + 11'd6;
    assign crc_rx      = {trail_reg, data_byte};
    assign crc_upd     = crc24q_byte(in_frame_reg ? crc_reg : 24'd0, data_byte);
    assign at_last     = in_frame_reg && (pos_reg >= 11'd3) && (pos_reg == last_pos);

    always_comb
    begin
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        plen_next     = plen_reg;
        crc_next      = crc_reg;
        hdr1_next     = hdr1_reg;
        first_pl_next = first_pl_reg;
        type_next     = type_reg;
        trail_next    = trail_reg;

        res_valid        = 1'b0;
        res.out_byte     = data_byte;
        res.frame_start  = 1'b0;
        res.frame_last   = 1'b0;
        res.verdict      = VERDICT_GOOD;
        res.message_type = 12'd0;
        res.frame_length = 11'd0;

        if (!in_frame_reg)
        begin
            // Hunting: only a preamble opens a frame, anything else is dropped.
            if (data_byte == PREAMBLE)
            begin
                in_frame_next   = 1'b1;
                crc_next        = crc_upd;
                pos_next        = 11'd1;
                plen_next       = 10'd0;
                trail_next      = 16'd0;
                res_valid       = 1'b1;
                res.frame_start = 1'b1;
            end
        end
        else
        begin
            res_valid = 1'b1;
            pos_next  = pos_reg + 11'd1;
            if (pos_reg == 11'd1)
            begin
                hdr1_next = data_byte;
                crc_next  = crc_upd;
            end
            else if (pos_reg == 11'd2)
            begin
                // Only the low two bits of the first header byte carry length.
                plen_next = {hdr1_reg[1:0], data_byte};
                crc_next  = crc_upd;
            end
            else
            begin
                if (pos_reg == 11'd3)
                begin
                    first_pl_next = data_byte;
                end
                if (pos_reg == 11'd4)
                begin
                    type_next = {first_pl_reg, data_byte[7:4]};
                end
                if (pos_reg < crc_end_pos)
                begin
                    crc_next = crc_upd;
                end
                else if (pos_reg == last_pos)
                begin
                    // Final CRC byte: a CRC mismatch wins over the filter.
                    res.frame_last   = 1'b1;
                    res.message_type = type_reg;
                    res.frame_length = total_len;
                    if (crc_rx != crc_reg)
                    begin
                        res.verdict = VERDICT_CRC_ERR;
                    end
                    else if (filter_enable_reg && (type_reg == filter_type_reg) &&
                             (total_len <= filter_limit_reg))
                    begin
                        res.verdict = VERDICT_FILTERED;
                    end
                    in_frame_next = 1'b0;
                    pos_next      = 11'd0;
                    plen_next     = 10'd0;
                    crc_next      = 24'd0;
                    trail_next    = 16'd0;
                end
                else
                begin
                    trail_next = {trail_reg[7:0], data_byte};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            pos_reg      <= 11'd0;
            plen_reg     <= 10'd0;
            crc_reg      <= 24'd0;
            hdr1_reg     <= 8'd0;
            first_pl_reg <= 8'd0;
            type_reg     <= 12'd0;
            trail_reg    <= 16'd0;
        end
        else if (byte_take)
        begin
            in_frame_reg <= in_frame_next;
            pos_reg      <= pos_next;
            plen_reg     <= plen_next;
            crc_reg      <= crc_next;
            hdr1_reg     <= hdr1_next;
            first_pl_reg <= first_pl_next;
            type_reg     <= type_next;
            trail_reg    <= trail_next;
        end
    end

    // ------------------------------------------------------------------
    // Output stage: result register backed by one skid register. The input
    // is held off only while the skid register is occupied.
    // ------------------------------------------------------------------
    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_reg;
    result_t skid_reg;
    logic    out_free;

    assign out_free   = !out_valid_reg || !result_stall;
    assign byte_stall = skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (byte_take && res_valid)
        begin
            if (out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (out_free)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_free)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (byte_take && res_valid)
        begin
            if (out_free)
            begin
                out_reg <= res;
            end
            else
            begin
                skid_reg <= res;
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign out_byte     = out_reg.out_byte;
    assign frame_start  = out_reg.frame_start;
    assign frame_last   = out_reg.frame_last;
    assign verdict      = out_reg.verdict;
    assign message_type = out_reg.message_type;
    assign frame_length = out_reg.frame_length;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `RFC_ASSERT_IMPL(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid holds item while output empty")
    `RFC_ASSERT_IMPL(a_start_not_last, out_valid_reg && out_reg.frame_start, !out_reg.frame_last, "item tagged both start and last")
    `RFC_ASSERT_IMPL(a_verdict_only_last, out_valid_reg && !out_reg.frame_last, out_reg.verdict == VERDICT_GOOD && out_reg.frame_length == 11'd0, "verdict fields set on a non-final item")
    `RFC_ASSERT_NEXT(a_frame_closes, byte_take && at_last, !in_frame_reg && pos_reg == 11'd0, "framer did not return to hunt after last byte")
    `RFC_ASSERT_IMPL(a_pos_bounded, in_frame_reg && pos_reg >= 11'd3, pos_reg <= last_pos, "byte position ran past the frame end")

endmodule
